>>> sv/midi_control_surface_decoder_core_defines.svh
// Assertion macros for the MIDI control surface decoder checker.
// No dependencies; included by the checker file only.
`ifndef MIDI_CONTROL_SURFACE_DECODER_CORE_DEFINES_SVH
`define MIDI_CONTROL_SURFACE_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCSD_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("mcsd checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define MCSD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("mcsd checker: next-cycle property failed");

`endif

>>> sv/mcsd_pkg.sv
// Shared types, codes and constants for the MIDI control surface decoder.
// No dependencies; imported by every RTL module of the block.
package mcsd_pkg;

  localparam int NUM_CONTROLS_DEF = 9;
  localparam int CTRL_IDX_W       = 4;
  localparam int BYTE_W           = 8;
  localparam int OPC_W            = 3;
  localparam int TRANSPORT_NUM    = 6;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [OPC_W-1:0] OP_BYTE      = 3'd0;
  localparam logic [OPC_W-1:0] OP_SLIDER    = 3'd1;
  localparam logic [OPC_W-1:0] OP_KNOB      = 3'd2;
  localparam logic [OPC_W-1:0] OP_BUTTON    = 3'd3;
  localparam logic [OPC_W-1:0] OP_TRANSPORT = 3'd4;
  localparam logic [OPC_W-1:0] OP_FRESH     = 3'd5;

  localparam logic [BYTE_W-1:0] SLIDER_LO    = 8'd3;
  localparam logic [BYTE_W-1:0] SLIDER_HI    = 8'd11;
  localparam logic [BYTE_W-1:0] KNOB_LO      = 8'd14;
  localparam logic [BYTE_W-1:0] KNOB_HI      = 8'd22;
  localparam logic [BYTE_W-1:0] BUTTON_LO    = 8'd23;
  localparam logic [BYTE_W-1:0] BUTTON_HI    = 8'd31;
  localparam logic [BYTE_W-1:0] TRANSPORT_LO = 8'd44;
  localparam logic [BYTE_W-1:0] TRANSPORT_HI = 8'd49;

  localparam logic [BYTE_W-1:0] FLAG_VALUE   = 8'd127;
  localparam logic [BYTE_W-1:0] STATUS_RESET = 8'd176;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_PACKET,
    CMD_SLIDER,
    CMD_KNOB,
    CMD_BUTTON,
    CMD_TRANSPORT,
    CMD_FRESH
  } cmd_kind_t;

  typedef enum logic [2:0] {
    TGT_NONE,
    TGT_SLIDER,
    TGT_KNOB,
    TGT_BUTTON,
    TGT_TRANSPORT
  } tgt_t;

  // idx: query index, transport slot, or controller offset of a packet
  typedef struct packed {
    cmd_kind_t             kind;
    tgt_t                  tgt;
    logic [CTRL_IDX_W-1:0] idx;
    logic [BYTE_W-1:0]     value;
  } cmd_t;

  // transport query index -> flag slot (slot = controller - 44)
  function automatic logic [2:0] transport_slot(input logic [2:0] q);
    logic [2:0] s;
    case (q)
      3'd0:    s = 3'd1;
      3'd1:    s = 3'd2;
      3'd2:    s = 3'd0;
      3'd3:    s = 3'd5;
      3'd4:    s = 3'd4;
      3'd5:    s = 3'd3;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

>>> sv/mcsd_front.sv
// Front end: groups bytes into three-byte packets and classifies every item
// into a command for the back end. Depends on mcsd_pkg.
module mcsd_front #(
  parameter int NUM_CONTROLS = mcsd_pkg::NUM_CONTROLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [mcsd_pkg::OPC_W-1:0]    opcode,
  input  logic [mcsd_pkg::CTRL_IDX_W-1:0] item_index,
  input  logic [mcsd_pkg::BYTE_W-1:0]   rx_byte,
  input  logic [mcsd_pkg::BYTE_W-1:0]   status_match,
  output mcsd_pkg::cmd_t                cmd
);
  import mcsd_pkg::*;

  localparam logic [CTRL_IDX_W:0] NUM_LIM = (CTRL_IDX_W+1)'(NUM_CONTROLS);

  logic [1:0]        phase_r, phase_nxt;
  logic [BYTE_W-1:0] held_r [2];
  logic [BYTE_W-1:0] ctrl;
  logic [BYTE_W-1:0] off;
  logic              off_ok;
  logic              idx_ok;
  tgt_t              tgt;

  assign ctrl   = held_r[1];
  assign idx_ok = {1'b0, item_index} < NUM_LIM;

  // controller classification for a completed packet
  always_comb begin
    tgt = TGT_NONE;
    off = '0;
    if (held_r[0] == status_match) begin
      if (ctrl inside {[SLIDER_LO:SLIDER_HI]}) begin
        off = ctrl - SLIDER_LO;
        tgt = TGT_SLIDER;
      end else if (ctrl inside {[KNOB_LO:KNOB_HI]}) begin
        off = ctrl - KNOB_LO;
        tgt = TGT_KNOB;
      end else if (ctrl inside {[BUTTON_LO:BUTTON_HI]}) begin
        off = ctrl - BUTTON_LO;
        tgt = (rx_byte != '0) ? TGT_BUTTON : TGT_NONE;
      end else if (ctrl inside {[TRANSPORT_LO:TRANSPORT_HI]}) begin
        off = ctrl - TRANSPORT_LO;
        tgt = (rx_byte != '0) ? TGT_TRANSPORT : TGT_NONE;
      end
    end
  end

  assign off_ok = (tgt == TGT_TRANSPORT) || ({1'b0, off[CTRL_IDX_W-1:0]} < NUM_LIM);

  always_comb begin
    cmd.kind  = CMD_NONE;
    cmd.tgt   = TGT_NONE;
    cmd.idx   = item_index;
    cmd.value = '0;
    phase_nxt = phase_r;
    case (opcode)
      OP_BYTE: begin
        if (phase_r >= 2'd2) begin
          cmd.kind  = CMD_PACKET;
          cmd.tgt   = off_ok ? tgt : TGT_NONE;
          cmd.idx   = off[CTRL_IDX_W-1:0];
          cmd.value = rx_byte;
          phase_nxt = 2'd0;
        end else begin
          phase_nxt = phase_r + 2'd1;
        end
      end
      OP_SLIDER:    if (idx_ok) cmd.kind = CMD_SLIDER;
      OP_KNOB:      if (idx_ok) cmd.kind = CMD_KNOB;
      OP_BUTTON:    if (idx_ok) cmd.kind = CMD_BUTTON;
      OP_TRANSPORT: begin
        if (item_index < CTRL_IDX_W'(TRANSPORT_NUM)) begin
          cmd.kind = CMD_TRANSPORT;
          cmd.idx  = {1'b0, transport_slot(item_index[2:0])};
        end
      end
      OP_FRESH:     cmd.kind = CMD_FRESH;
      default:      cmd.kind = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && opcode == OP_BYTE && phase_r < 2'd2) begin
      held_r[phase_r[0]] <= rx_byte;
    end
  end

endmodule

>>> sv/mcsd_queue.sv
// Short command queue between front and back end.
// Depends on mcsd_pkg for the command type and the depth.
module mcsd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mcsd_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output mcsd_pkg::cmd_t head
);
  import mcsd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = count_r == CNT_W'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> sv/mcsd_back.sv
// Back end: holds the control surface state, executes commands in order
// and drives the result register. Depends on mcsd_pkg.
module mcsd_back #(
  parameter int NUM_CONTROLS = mcsd_pkg::NUM_CONTROLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  input  mcsd_pkg::cmd_t              cmd,
  output logic                        cmd_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mcsd_pkg::BYTE_W-1:0] out_read_value,
  output logic                        out_packet_done
);
  import mcsd_pkg::*;

  localparam int IDX_W = (NUM_CONTROLS > 1) ? $clog2(NUM_CONTROLS) : 1;

  logic [BYTE_W-1:0]        slider_r [NUM_CONTROLS];
  logic [BYTE_W-1:0]        knob_r   [NUM_CONTROLS];
  logic [NUM_CONTROLS-1:0]  button_r;
  logic [TRANSPORT_NUM-1:0] transport_r;
  logic                     fresh_r;
  logic                     out_valid_r;
  logic [BYTE_W-1:0]        read_value_r, read_value_nxt;
  logic                     packet_done_r;
  logic [IDX_W-1:0]         ci;
  logic [2:0]               slot;

  assign ci      = cmd.idx[IDX_W-1:0];
  assign slot    = cmd.idx[2:0];
  assign cmd_pop = cmd_valid && (!out_valid_r || !out_stall);

  always_comb begin
    read_value_nxt = '0;
    case (cmd.kind)
      CMD_SLIDER:    read_value_nxt = slider_r[ci];
      CMD_KNOB:      read_value_nxt = knob_r[ci];
      CMD_BUTTON:    read_value_nxt = {{(BYTE_W-1){1'b0}}, button_r[ci]};
      CMD_TRANSPORT: read_value_nxt = transport_r[slot] ? FLAG_VALUE : '0;
      CMD_FRESH:     read_value_nxt = {{(BYTE_W-1){1'b0}}, fresh_r};
      default:       read_value_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CONTROLS; i++) begin
        slider_r[i] <= '0;
        knob_r[i]   <= '0;
      end
      button_r    <= '0;
      transport_r <= '0;
      fresh_r     <= 1'b1;
    end else if (cmd_pop) begin
      case (cmd.kind)
        CMD_PACKET: begin
          fresh_r <= 1'b1;
          case (cmd.tgt)
            TGT_SLIDER:    slider_r[ci]      <= cmd.value;
            TGT_KNOB:      knob_r[ci]        <= cmd.value;
            TGT_BUTTON:    button_r[ci]      <= ~button_r[ci];
            TGT_TRANSPORT: transport_r[slot] <= 1'b1;
            default:       ;
          endcase
        end
        CMD_TRANSPORT: transport_r[slot] <= 1'b0;
        CMD_FRESH:     fresh_r           <= 1'b0;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= cmd_pop;
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      read_value_r  <= read_value_nxt;
      packet_done_r <= cmd.kind == CMD_PACKET;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = read_value_r;
  assign out_packet_done = packet_done_r;

endmodule

>>> sv/midi_control_surface_decoder_core.sv
// MIDI control surface decoder. Takes one byte or query beat per cycle
// while the command queue is not full. A result beat is registered in the
// command queue and then in the back end's result register. A two-entry
// queue lets the front keep accepting while a result is stalled; in_stall
// rises only when the queue is full. The user must write status_match
// through the cfg port (always ready) only while idle; the block does not
// enforce this. Reset is synchronous, with no clearing pass.
// Depends on mcsd_pkg, mcsd_front, mcsd_queue and mcsd_back.
module midi_control_surface_decoder_core #(
  parameter int NUM_CONTROLS = mcsd_pkg::NUM_CONTROLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mcsd_pkg::BYTE_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mcsd_pkg::OPC_W-1:0]      in_opcode,
  input  logic [mcsd_pkg::CTRL_IDX_W-1:0] in_item_index,
  input  logic [mcsd_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mcsd_pkg::BYTE_W-1:0]     out_read_value,
  output logic                            out_packet_done
);
  import mcsd_pkg::*;

  logic [BYTE_W-1:0] status_match_r;
  logic              accept;
  logic              q_full;
  logic              q_not_empty;
  logic              q_pop;
  cmd_t              front_cmd;
  cmd_t              head_cmd;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_match_r <= STATUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      status_match_r <= cfg_data;
    end
  end

  mcsd_front #(.NUM_CONTROLS(NUM_CONTROLS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .opcode       (in_opcode),
    .item_index   (in_item_index),
    .rx_byte      (in_rx_byte),
    .status_match (status_match_r),
    .cmd          (front_cmd)
  );

  mcsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_cmd  (front_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_cmd)
  );

  mcsd_back #(.NUM_CONTROLS(NUM_CONTROLS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (q_not_empty),
    .cmd             (head_cmd),
    .cmd_pop         (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_value  (out_read_value),
    .out_packet_done (out_packet_done)
  );

endmodule

>>> sv/mcsd_checker.sv
// Port-level checker for the MIDI control surface decoder, with its bind.
// Depends on midi_control_surface_decoder_core_defines.svh and mcsd_pkg.
`include "midi_control_surface_decoder_core_defines.svh"

module mcsd_port_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [mcsd_pkg::BYTE_W-1:0] out_read_value,
  input logic                        out_packet_done
);

  // a completed packet never carries a query answer
  `MCSD_ASSERT_NOW(a_done_zero_value, clk, rst_n, out_valid && out_packet_done,
                   out_read_value == '0)

  // the queue can only fill behind a held result
  `MCSD_ASSERT_NOW(a_stall_needs_result, clk, rst_n, in_stall, out_valid)

  // stall on the input rises only after an accepted beat
  `MCSD_ASSERT_NOW(a_stall_after_push, clk, rst_n, $rose(in_stall),
                   $past(in_valid && !in_stall))

  `MCSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                    out_valid && $stable(out_read_value) && $stable(out_packet_done))

endmodule

bind midi_control_surface_decoder_core mcsd_port_checker u_mcsd_checker (.*);

>>> tb/mcsd_checker.sv
// Checker for the MIDI control surface decoder: watches the cfg, in and out channels.
// It predicts each result beat from the accepted input beats and compares them in order.
// Depends on mcsd_pkg.
module mcsd_checker #(
  parameter int NUM_CONTROLS = mcsd_pkg::NUM_CONTROLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [mcsd_pkg::BYTE_W-1:0]     cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [mcsd_pkg::OPC_W-1:0]      in_opcode,
  input  logic [mcsd_pkg::CTRL_IDX_W-1:0] in_item_index,
  input  logic [mcsd_pkg::BYTE_W-1:0]     in_rx_byte,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [mcsd_pkg::BYTE_W-1:0]     out_read_value,
  input  logic                            out_packet_done,
  output int                              fail_count,
  output int                              pending,
  output int                              checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import mcsd_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] read_value;
    logic              packet_done;
  } answer_t;

  // shadow copy of the decoder state
  logic [1:0]        byte_phase;
  logic [BYTE_W-1:0] held_bytes [2];
  logic [BYTE_W-1:0] slider_vals [16];
  logic [BYTE_W-1:0] knob_vals [16];
  logic              button_bits [16];
  logic              transport_flags [TRANSPORT_NUM];
  logic              fresh_flag;
  logic [BYTE_W-1:0] match_status;

  answer_t awaited_answers[$];
  answer_t oldest;
  int mismatches = 0;
  int compared = 0;
  int waiting = 0;

  assign fail_count = mismatches;
  assign pending    = waiting;
  assign checked    = compared;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Applies one accepted beat to the shadow state and returns the answer it must produce.
  function automatic answer_t decoder_answer(input logic [OPC_W-1:0] op,
                                             input logic [CTRL_IDX_W-1:0] idx,
                                             input logic [BYTE_W-1:0] rx);
    answer_t ans;
    logic [BYTE_W-1:0] ctl;
    int off;
    int slot;
    ans = '0;
    case (op)
      OP_BYTE: begin
        if (byte_phase == 2'd2) begin
          ctl = held_bytes[1];
          fresh_flag = 1'b1;
          byte_phase = 2'd0;
          ans.packet_done = 1'b1;
          if (held_bytes[0] == match_status) begin
            if (ctl >= SLIDER_LO && ctl <= SLIDER_HI) begin
              off = int'(ctl) - int'(SLIDER_LO);
              if (off < NUM_CONTROLS) slider_vals[off] = rx;
            end else if (ctl >= KNOB_LO && ctl <= KNOB_HI) begin
              off = int'(ctl) - int'(KNOB_LO);
              if (off < NUM_CONTROLS) knob_vals[off] = rx;
            end else if (ctl >= BUTTON_LO && ctl <= BUTTON_HI) begin
              off = int'(ctl) - int'(BUTTON_LO);
              if (rx != '0 && off < NUM_CONTROLS) button_bits[off] = ~button_bits[off];
            end else if (ctl >= TRANSPORT_LO && ctl <= TRANSPORT_HI) begin
              if (rx != '0) transport_flags[int'(ctl) - int'(TRANSPORT_LO)] = 1'b1;
            end
          end
        end else begin
          held_bytes[byte_phase] = rx;
          byte_phase = byte_phase + 2'd1;
        end
      end
      OP_SLIDER: if (idx < NUM_CONTROLS) ans.read_value = slider_vals[idx];
      OP_KNOB:   if (idx < NUM_CONTROLS) ans.read_value = knob_vals[idx];
      OP_BUTTON: if (idx < NUM_CONTROLS) ans.read_value = {7'd0, button_bits[idx]};
      OP_TRANSPORT: begin
        if (idx < TRANSPORT_NUM) begin
          // query order start, stop, record, loop, ff, rewind; flags kept by controller
          case (idx)
            4'd0:    slot = 1;
            4'd1:    slot = 2;
            4'd2:    slot = 0;
            4'd3:    slot = 5;
            4'd4:    slot = 4;
            default: slot = 3;
          endcase
          if (transport_flags[slot]) begin
            transport_flags[slot] = 1'b0;
            ans.read_value = FLAG_VALUE;
          end
        end
      end
      OP_FRESH: begin
        if (fresh_flag) begin
          fresh_flag = 1'b0;
          ans.read_value = 8'd1;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      byte_phase = 2'd0;
      held_bytes[0] = '0;
      held_bytes[1] = '0;
      for (int i = 0; i < 16; i++) begin
        slider_vals[i] = '0;
        knob_vals[i] = '0;
        button_bits[i] = 1'b0;
      end
      for (int i = 0; i < TRANSPORT_NUM; i++) transport_flags[i] = 1'b0;
      fresh_flag = 1'b1;
      match_status = STATUS_RESET;
      awaited_answers.delete();
    end else begin
      if (cfg_valid && cfg_ready) match_status = cfg_data;
      if (out_valid && !out_stall) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat: read_value %0d packet_done %0b",
                                    out_read_value, out_packet_done));
        end else begin
          oldest = awaited_answers.pop_front();
          compared++;
          if (out_read_value !== oldest.read_value)
            report_mismatch($sformatf("read_value got %0d, want %0d",
                                      out_read_value, oldest.read_value));
          if (out_packet_done !== oldest.packet_done)
            report_mismatch($sformatf("packet_done got %0b, want %0b",
                                      out_packet_done, oldest.packet_done));
        end
      end
      if (in_valid && !in_stall)
        awaited_answers.push_back(decoder_answer(in_opcode, in_item_index, in_rx_byte));
    end
    waiting = awaited_answers.size();
  end

endmodule

>>> tb/tb_midi_control_surface_decoder_core.sv
// Top of the MIDI control surface decoder testbench: clock, reset, stimulus and verdict.
// It drives directed and random beats under four handshake modes and several status values.
// Depends on mcsd_pkg, midi_control_surface_decoder_core and mcsd_checker.
module tb_midi_control_surface_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mcsd_pkg::*;

  localparam logic [OPC_W-1:0] OP_UNDEF_LO = 3'd6;
  localparam logic [OPC_W-1:0] OP_UNDEF_HI = 3'd7;

  localparam logic [CTRL_IDX_W-1:0] TQ_START  = 4'd0;
  localparam logic [CTRL_IDX_W-1:0] TQ_STOP   = 4'd1;
  localparam logic [CTRL_IDX_W-1:0] TQ_RECORD = 4'd2;
  localparam logic [CTRL_IDX_W-1:0] TQ_LOOP   = 4'd3;
  localparam logic [CTRL_IDX_W-1:0] TQ_FF     = 4'd4;
  localparam logic [CTRL_IDX_W-1:0] TQ_REWIND = 4'd5;

  localparam int ITEMS_PER_MODE = 500;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 20;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [BYTE_W-1:0]     cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OPC_W-1:0]      in_opcode = '0;
  logic [CTRL_IDX_W-1:0] in_item_index = '0;
  logic [BYTE_W-1:0]     in_rx_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BYTE_W-1:0]     out_read_value;
  logic                  out_packet_done;

  int fail_count;
  int pending;
  int checked;

  int idle_pct = 0;
  int stall_pct = 0;
  logic hold_go = 1'b0;
  logic hold_over = 1'b0;
  int items_sent = 0;
  int stream_phase = 0;
  int quiet_cycles = 0;
  logic [BYTE_W-1:0] cur_status = STATUS_RESET;

  always #1 clk = ~clk;

  midi_control_surface_decoder_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_item_index  (in_item_index),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_packet_done(out_packet_done)
  );

  mcsd_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_item_index  (in_item_index),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_packet_done(out_packet_done),
    .fail_count     (fail_count),
    .pending        (pending),
    .checked        (checked)
  );

  // receiver: random stall, or solid stall during the hold-off
  always @(negedge clk) begin
    out_stall <= (hold_go && !hold_over) || ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    wait (hold_go);
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_over <= 1'b1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken,
  // with valid still high.
  task automatic send_item(input logic [OPC_W-1:0] op, input logic [CTRL_IDX_W-1:0] idx,
                           input logic [BYTE_W-1:0] rx);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_item_index <= idx;
    in_rx_byte    <= rx;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
    if (op == OP_BYTE) stream_phase = (stream_phase + 1) % 3;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] rx);
    send_item(OP_BYTE, CTRL_IDX_W'($urandom), rx);
  endtask

  task automatic send_query();
    logic [OPC_W-1:0] op;
    logic [CTRL_IDX_W-1:0] idx;
    case ($urandom_range(0, 4))
      0:       op = OP_SLIDER;
      1:       op = OP_KNOB;
      2:       op = OP_BUTTON;
      3:       op = OP_TRANSPORT;
      default: op = OP_FRESH;
    endcase
    if ($urandom_range(0, 3) == 0)
      idx = CTRL_IDX_W'($urandom_range(0, 15));
    else if (op == OP_TRANSPORT)
      idx = CTRL_IDX_W'($urandom_range(0, TRANSPORT_NUM - 1));
    else
      idx = CTRL_IDX_W'($urandom_range(0, NUM_CONTROLS_DEF - 1));
    send_item(op, idx, BYTE_W'($urandom));
  endtask

  // Well-formed packet, realigned to the stream first; queries may sit between its bytes.
  task automatic send_packet();
    logic [BYTE_W-1:0] st;
    logic [BYTE_W-1:0] ctl;
    logic [BYTE_W-1:0] val;
    while (stream_phase != 0) send_byte(BYTE_W'($urandom));
    st = ($urandom_range(0, 4) != 0) ? cur_status : BYTE_W'($urandom);
    case ($urandom_range(0, 9))
      0, 1:    ctl = BYTE_W'($urandom_range(SLIDER_LO, SLIDER_HI));
      2, 3:    ctl = BYTE_W'($urandom_range(KNOB_LO, KNOB_HI));
      4, 5:    ctl = BYTE_W'($urandom_range(BUTTON_LO, BUTTON_HI));
      6, 7:    ctl = BYTE_W'($urandom_range(TRANSPORT_LO, TRANSPORT_HI));
      8:       ctl = BYTE_W'($urandom);
      default: ctl = BYTE_W'($urandom_range(0, 63));
    endcase
    case ($urandom_range(0, 9))
      0, 1:    val = '0;
      2:       val = '1;
      default: val = BYTE_W'($urandom);
    endcase
    send_byte(st);
    if ($urandom_range(0, 9) == 0) send_query();
    send_byte(ctl);
    if ($urandom_range(0, 9) == 0) send_query();
    send_byte(val);
  endtask

  task automatic write_status(input logic [BYTE_W-1:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_status = value;
  endtask

  initial begin
    logic [BYTE_W-1:0] mid_status;
    logic [BYTE_W-1:0] mode_status;
    int quota;
    int act;
    mid_status = BYTE_W'($urandom_range(1, 254));
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset status, range edges, every query kind and the corner cases
    send_item(OP_FRESH, 4'd15, 8'd0);
    send_byte(STATUS_RESET); send_byte(SLIDER_LO);           send_byte(8'd255);
    send_byte(STATUS_RESET); send_byte(KNOB_HI);             send_byte(8'd128);
    send_byte(STATUS_RESET); send_byte(BUTTON_LO);           send_byte(8'd1);
    send_byte(STATUS_RESET); send_byte(TRANSPORT_LO + 8'd1); send_byte(8'd127);
    send_byte(8'd0);         send_byte(SLIDER_HI);           send_byte(8'd77);
    send_item(OP_SLIDER, 4'd0, 8'd0);
    send_item(OP_SLIDER, 4'd15, 8'd0);
    send_item(OP_KNOB, 4'd8, 8'd0);
    send_item(OP_BUTTON, 4'd0, 8'd0);
    send_item(OP_TRANSPORT, TQ_START, 8'd0);
    send_item(OP_TRANSPORT, TQ_START, 8'd0);
    send_item(OP_TRANSPORT, TQ_STOP, 8'd0);
    send_item(OP_TRANSPORT, TQ_RECORD, 8'd0);
    send_item(OP_TRANSPORT, TQ_LOOP, 8'd0);
    send_item(OP_TRANSPORT, TQ_FF, 8'd0);
    send_item(OP_TRANSPORT, TQ_REWIND, 8'd0);
    send_item(OP_TRANSPORT, 4'd15, 8'd0);
    send_item(OP_FRESH, 4'd0, 8'd0);
    send_item(OP_UNDEF_HI, 4'd15, 8'd255);

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin idle_pct = 0;  stall_pct <= 0;  mode_status = 8'd255;       end
        1: begin idle_pct = 88; stall_pct <= 0;  mode_status = 8'd0;         end
        2: begin idle_pct = 0;  stall_pct <= 88; mode_status = mid_status;   end
        default: begin
          idle_pct = 38; stall_pct <= 38; mode_status = STATUS_RESET;
        end
      endcase
      write_status(mode_status);
      quota = items_sent + ITEMS_PER_MODE;
      while (items_sent < quota) begin
        // long output hold-off while input keeps coming, so the queue fills
        if (mode == 0 && !hold_go && items_sent >= quota - ITEMS_PER_MODE + 100)
          hold_go <= 1'b1;
        act = $urandom_range(0, 99);
        if (act < 55)
          send_packet();
        else if (act < 85)
          send_query();
        else if (act < 95)
          send_byte(BYTE_W'($urandom));
        else
          send_item(($urandom_range(0, 1) != 0) ? OP_UNDEF_LO : OP_UNDEF_HI,
                    CTRL_IDX_W'($urandom), BYTE_W'($urandom));
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d beats over four handshake modes with a %0d-cycle output hold-off,",
             items_sent, HOLD_CYCLES);
    $display("status values 176, 255, 0 and %0d; %0d result beats compared.",
             mid_status, checked);
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
